>>> hdl/slot_free_list_allocator_core_assert.svh
// Assertion macros for the slot free-list allocator core.
// Used by the top level only; the checks fold away when SYNTHESIS is defined.
`ifndef SLOT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SLOT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define SFLA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define SFLA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot allocator check failed");

`else

`define SFLA_ASSERT_IMP(lbl, ante, cons)
`define SFLA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hdl/sfla_pkg.sv
// Shared types and constants of the slot free-list allocator.
// Used by sfla_ctrl, sfla_dp and slot_free_list_allocator_core; depends on nothing.
package sfla_pkg;

    localparam int SLOTS  = 16384;
    localparam int SLOT_W = 14;
    localparam int CNT_W  = 15;
    localparam int LOCK_W = 13;
    localparam int OWN_W  = 32;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_wr;
        logic load;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/sfla_ctrl.sv
// Controller of the slot free-list allocator: link memory init, accept, execute.
// Depends on sfla_pkg.
module sfla_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sfla_pkg::t_sts i_sts,
    output sfla_pkg::t_cmd o_cmd
);
    import sfla_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;

    assign o_req_ready  = (r_state == S_IDLE) && i_sts.out_free;
    assign o_cmd.init_wr = (r_state == S_INIT);
    assign o_cmd.load    = i_req_valid && o_req_ready;
    assign o_cmd.exec    = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            case (r_state)
                S_INIT: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

endmodule

>>> hdl/sfla_dp.sv
// Datapath of the slot free-list allocator: link and owner memories, list
// pointers, free counter and result register. Depends on sfla_pkg.
module sfla_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfla_pkg::t_cmd              i_cmd,
    output sfla_pkg::t_sts              o_sts,
    input  logic                        i_mode,
    input  logic [sfla_pkg::OWN_W-1:0]  i_owner_id,
    input  logic [sfla_pkg::SLOT_W-1:0] i_release_slot,
    input  logic                        i_m_ready,
    output logic                        o_m_valid,
    output logic [sfla_pkg::SLOT_W-1:0] o_granted_slot,
    output logic [sfla_pkg::LOCK_W-1:0] o_lock_group,
    output sfla_pkg::t_status           o_status,
    output logic [sfla_pkg::CNT_W-1:0]  o_free_count
);
    import sfla_pkg::*;

    logic [SLOT_W-1:0] link_mem  [SLOTS];
    logic [OWN_W-1:0]  owner_mem [SLOTS];

    logic [SLOT_W-1:0] r_clr_idx;
    logic              r_mode;
    logic [OWN_W-1:0]  r_owner;
    logic [SLOT_W-1:0] r_rel;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [CNT_W-1:0]  r_remaining, n_remaining;
    logic [SLOT_W-1:0] r_link;

    logic              r_m_valid;
    logic [SLOT_W-1:0] r_m_slot, n_m_slot;
    t_status           r_m_status, n_m_status;
    logic [CNT_W-1:0]  r_m_free;

    logic              alloc_ok, rel_ok;
    logic [SLOT_W-1:0] link_next;
    logic [CNT_W-1:0]  clr_plus;
    logic [SLOT_W-1:0] clr_data;
    logic              lw_en;
    logic [SLOT_W-1:0] lw_addr, lw_data;
    logic              ow_en;
    logic [SLOT_W-1:0] ow_addr;
    logic [OWN_W-1:0]  ow_data;

    assign alloc_ok = (r_mode == MODE_ALLOC) && !r_empty
                   && (CNT_W'(r_head) < CNT_W'(SLOTS));
    assign rel_ok   = (r_mode == MODE_RELEASE) && (CNT_W'(r_rel) < CNT_W'(SLOTS));

    // A link that points past the pool is taken as slot zero.
    assign link_next = (CNT_W'(r_link) < CNT_W'(SLOTS)) ? r_link : '0;

    assign clr_plus = CNT_W'(r_clr_idx) + CNT_W'(1);
    assign clr_data = (clr_plus < CNT_W'(SLOTS)) ? clr_plus[SLOT_W-1:0] : '0;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_remaining = r_remaining;
        n_m_slot    = '0;
        n_m_status  = ST_OK;
        if (r_mode == MODE_ALLOC) begin
            if (alloc_ok) begin
                n_m_slot = r_head;
                if (r_head == r_tail) begin
                    n_empty = 1'b1;
                end else begin
                    n_head = link_next;
                end
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - CNT_W'(1);
                end
            end else begin
                n_m_status = ST_EXHAUSTED;
            end
        end else begin
            if (rel_ok) begin
                if (r_empty) begin
                    n_head  = r_rel;
                    n_empty = 1'b0;
                end
                n_tail = r_rel;
                if (r_remaining < CNT_W'(SLOTS)) begin
                    n_remaining = r_remaining + CNT_W'(1);
                end
            end else begin
                n_m_status = ST_BAD_INDEX;
            end
        end
    end

    // One write port each: link sweep or tail append, owner record on execute.
    assign lw_en   = i_cmd.init_wr || (i_cmd.exec && rel_ok && !r_empty);
    assign lw_addr = i_cmd.init_wr ? r_clr_idx : r_tail;
    assign lw_data = i_cmd.init_wr ? clr_data : r_rel;

    assign ow_en   = i_cmd.exec && (alloc_ok || rel_ok);
    assign ow_addr = alloc_ok ? r_head : r_rel;
    assign ow_data = alloc_ok ? r_owner : '0;

    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            link_mem[lw_addr] <= lw_data;
        end
        r_link <= link_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (ow_en) begin
            owner_mem[ow_addr] <= ow_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_owner <= i_owner_id;
            r_rel   <= i_release_slot;
        end
        if (i_cmd.exec) begin
            r_m_slot   <= n_m_slot;
            r_m_status <= n_m_status;
            r_m_free   <= n_remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_head      <= '0;
            r_tail      <= SLOT_W'(SLOTS - 1);
            r_empty     <= 1'b0;
            r_remaining <= CNT_W'(SLOTS);
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_clr_idx <= r_clr_idx + SLOT_W'(1);
            end
            if (i_cmd.exec) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_empty     <= n_empty;
                r_remaining <= n_remaining;
                r_m_valid   <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_idx == SLOT_W'(SLOTS - 1));
    assign o_sts.out_free = !r_m_valid || i_m_ready;

    assign o_m_valid      = r_m_valid;
    assign o_granted_slot = r_m_slot;
    assign o_lock_group   = r_m_slot[LOCK_W-1:0];
    assign o_status       = r_m_status;
    assign o_free_count   = r_m_free;

endmodule

>>> hdl/slot_free_list_allocator_core.sv
// Slot free-list allocator core: hands out and takes back slots of a fixed pool.
// The slave stream carries requests: tuser is the mode (0 allocate, 1 release),
// tdata the owner id and the slot to release. The master stream returns one
// result per request: granted slot, lock group, free count, and status in tuser.
// A request is accepted in the idle state and its result is registered in the
// execute cycle after it; the rate is set by the synchronous read of the link
// memory at the head, which is issued at the accept edge and used in the
// execute cycle. Requests are handled one at a time.
// After reset the link memory is swept to chain slot 0 through slot SLOTS-1 in
// order, and s_tready stays low during the sweep.
// The result sits in an output register. A new request is taken while that
// register is full only if the receiver takes the result at the same edge; a
// stalled receiver therefore holds off further requests and nothing is lost.
// Depends on sfla_pkg, sfla_ctrl, sfla_dp and the assertion macro header.
`include "slot_free_list_allocator_core_assert.svh"

module slot_free_list_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // owner_id[31:0], release_slot[45:32], zero pad
    input  logic [0:0]  s_tuser,   // mode[0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // granted_slot[13:0], lock_group[26:14],
                                   // free_count[41:27], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import sfla_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [SLOT_W-1:0] granted_slot;
    logic [LOCK_W-1:0] lock_group;
    t_status           status;
    logic [CNT_W-1:0]  free_count;

    // The controller sequences the init sweep and one request at a time.
    sfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the free chain, the owner records and the result.
    sfla_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (s_tuser[0]),
        .i_owner_id     (s_tdata[OWN_W-1:0]),
        .i_release_slot (s_tdata[OWN_W+SLOT_W-1:OWN_W]),
        .i_m_ready      (m_tready),
        .o_m_valid      (m_tvalid),
        .o_granted_slot (granted_slot),
        .o_lock_group   (lock_group),
        .o_status       (status),
        .o_free_count   (free_count)
    );

    assign m_tdata = {6'd0, free_count, lock_group, granted_slot};
    assign m_tuser = status;

    // A request is never followed by another in the very next cycle.
    `SFLA_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    // Every accepted request raises m_tvalid once its execute cycle is done.
    `SFLA_ASSERT_NXT(a_result_follows, s_tvalid && s_tready, ##1 m_tvalid)
    // An exhausted pool reports neither a slot nor a lock group.
    `SFLA_ASSERT_IMP(a_exhausted_empty, m_tvalid && (status == ST_EXHAUSTED), (granted_slot == '0) && (lock_group == '0))

endmodule
